FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define SAB_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define SAB_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/sab_pkg.sv
`default_nettype none
package sab_pkg;
    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int LW      = AW + 1;
    localparam int WW      = LW + 1;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NOSTR = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_INIT,
        S_RUN,
        S_LOAD,
        S_STEP,
        S_WCMP,
        S_NEXT
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_CHK,
        C_CMP
    } t_cstate;

    typedef struct packed {
        logic          start;
        logic [AW-1:0] p;
        logic [AW-1:0] q;
    } t_cmp_req;

    typedef struct packed {
        logic done;
        logic less;
    } t_cmp_rsp;
endpackage
`default_nettype wire

FILE: sv/sab_cmp.sv
`default_nettype none
module sab_cmp import sab_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_wr_en,
    input  wire [AW-1:0]   i_wr_addr,
    input  wire [7:0]      i_wr_data,
    input  wire [LW-1:0]   i_len,
    input  t_cmp_req       i_req,
    output t_cmp_rsp       o_rsp
);
    logic [7:0]    r_text [MAX_LEN];
    logic [7:0]    r_da, r_db;
    t_cstate       r_cst, n_cst;
    logic [LW-1:0] r_pi, n_pi, r_qi, n_qi;
    logic          r_done, n_done, r_less, n_less;
    logic          w_in_range;

    assign w_in_range = (r_pi < i_len) && (r_qi < i_len);

    always_comb begin
        n_cst = r_cst;
        case (r_cst)
            C_IDLE: if (i_req.start) n_cst = C_CHK;
            C_CHK:  n_cst = w_in_range ? C_CMP : C_IDLE;
            C_CMP:  n_cst = (r_da != r_db) ? C_IDLE : C_CHK;
            default: n_cst = C_IDLE;
        endcase
    end

    always_comb begin
        n_pi   = r_pi;
        n_qi   = r_qi;
        n_done = 1'b0;
        n_less = r_less;
        case (r_cst)
            C_IDLE: begin
                if (i_req.start) begin
                    n_pi = {1'b0, i_req.p};
                    n_qi = {1'b0, i_req.q};
                end
            end
            C_CHK: begin
                if (!w_in_range) begin
                    n_done = 1'b1;
                    n_less = (r_pi >= i_len) && (r_qi < i_len);
                end
            end
            C_CMP: begin
                if (r_da != r_db) begin
                    n_done = 1'b1;
                    n_less = r_da < r_db;
                end else begin
                    n_pi = r_pi + LW'(1);
                    n_qi = r_qi + LW'(1);
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.less = r_less;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst  <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_cst  <= n_cst;
            r_done <= n_done;
        end
        r_pi   <= n_pi;
        r_qi   <= n_qi;
        r_less <= n_less;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_text[i_wr_addr] <= i_wr_data;
        end
        r_da <= r_text[r_pi[AW-1:0]];
        r_db <= r_text[r_qi[AW-1:0]];
    end
endmodule
`default_nettype wire

FILE: sv/suffix_array_builder.sv
`default_nettype none
`include "assert_macros.svh"
// An append word is answered in the cycle after acceptance with the storage index of the
// byte. A read word that finds its entry passes through S_RDATA and is answered with the
// suffix start at the requested rank, and a read that is flagged is answered like an
// append. An append marked tlast starts the sort, during which s_tready stays low. The
// positions are first numbered in S_INIT. A bottom-up merge sort then runs ceil(log2(n))
// passes. In each pass an entry copied from a run that the other run has used up passes
// through S_LOAD and S_STEP, and an entry chosen by the single suffix compare unit also
// waits in S_WCMP while the unit steps through every matching byte. Each pair of runs
// also passes through S_RUN and S_NEXT. Long runs of repeated text dominate the sort.
module suffix_array_builder import sab_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [23:0] s_tdata,  // text_byte[7:0], rank[17:8], zeros above
    input  wire        s_tuser,  // cmd
    input  wire        s_tlast,  // last_byte
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata  // position[9:0], status[11:10], zeros above
);
    logic [AW-1:0] r_ord0 [MAX_LEN];
    logic [AW-1:0] r_ord1 [MAX_LEN];
    logic [AW-1:0] r_va0, r_vb0, r_va1, r_vb1;
    logic [AW-1:0] w_va, w_vb, w_rda;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_complete, n_complete, r_cur, n_cur;
    logic [WW-1:0] r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [WW-1:0] r_a, n_a, r_b, n_b, r_k, n_k;
    logic          r_ovalid, n_ovalid;
    logic [9:0]    r_opos, n_opos;
    t_status       r_ost, n_ost;

    logic          w_acc, w_run_a, w_run_b, w_full;
    logic [LW-1:0] w_base;
    logic [WW-1:0] w_n, w_mid, w_hi, w_lo2, w_w2;
    logic [9:0]    w_rank;
    logic          w_wr_en, w_wr_sel;
    logic [AW-1:0] w_wr_addr, w_wr_val;
    logic          w_txt_en;
    t_cmp_req      w_req;
    t_cmp_rsp      w_rsp;

    assign s_tready = (r_state == S_IDLE) && (!r_ovalid || m_tready);
    assign w_acc    = s_tvalid && s_tready;
    assign w_rank   = s_tdata[17:8];
    assign w_base   = r_complete ? '0 : r_len;
    assign w_full   = w_base >= LW'(MAX_LEN);
    assign w_n      = {1'b0, r_len};
    assign w_run_a  = r_a < r_mid;
    assign w_run_b  = r_b < r_hi;
    assign w_mid    = ((r_lo + r_w) < w_n) ? (r_lo + r_w) : w_n;
    assign w_hi     = ((w_mid + r_w) < w_n) ? (w_mid + r_w) : w_n;
    assign w_w2     = r_w << 1;
    assign w_lo2    = r_lo + w_w2;
    assign w_va     = r_cur ? r_va1 : r_va0;
    assign w_vb     = r_cur ? r_vb1 : r_vb0;
    assign w_rda    = (r_state == S_IDLE) ? w_rank[AW-1:0] : r_a[AW-1:0];

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {4'b0, r_ost, r_opos};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && s_tuser == CMD_READ && r_complete
                        && {1'b0, w_rank} < r_len) begin
                    n_state = S_RDATA;
                end else if (w_acc && s_tuser == CMD_APPEND && s_tlast) begin
                    n_state = S_INIT;
                end
            end
            S_RDATA: n_state = S_IDLE;
            S_INIT: begin
                if ((r_k + WW'(1)) >= w_n) begin
                    n_state = (w_n <= WW'(1)) ? S_IDLE : S_RUN;
                end
            end
            S_RUN:  n_state = S_LOAD;
            S_LOAD: n_state = S_STEP;
            S_STEP: begin
                if (w_run_a && w_run_b) begin
                    n_state = S_WCMP;
                end else if (w_run_a || w_run_b) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_WCMP: if (w_rsp.done) n_state = S_LOAD;
            S_NEXT: begin
                if (w_lo2 < w_n) begin
                    n_state = S_RUN;
                end else begin
                    n_state = (w_w2 >= w_n) ? S_IDLE : S_RUN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len      = r_len;
        n_complete = r_complete;
        n_cur      = r_cur;
        n_w        = r_w;
        n_lo       = r_lo;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_ovalid   = r_ovalid && !m_tready;
        n_opos     = r_opos;
        n_ost      = r_ost;
        w_wr_en    = 1'b0;
        w_wr_sel   = 1'b0;
        w_wr_addr  = r_k[AW-1:0];
        w_wr_val   = w_va;
        w_txt_en   = 1'b0;
        w_req      = '{start: 1'b0, p: w_vb, q: w_va};
        case (r_state)
            S_IDLE: begin
                if (w_acc && s_tuser == CMD_APPEND) begin
                    n_complete = 1'b0;
                    n_ovalid   = 1'b1;
                    if (w_full) begin
                        n_ost  = ST_FULL;
                        n_opos = '0;
                        n_len  = w_base;
                    end else begin
                        n_ost    = ST_OK;
                        n_opos   = 10'(w_base);
                        n_len    = w_base + LW'(1);
                        w_txt_en = 1'b1;
                    end
                    if (s_tlast) begin
                        n_k = '0;
                    end
                end else if (w_acc) begin
                    n_opos = '0;
                    if (!r_complete) begin
                        n_ovalid = 1'b1;
                        n_ost    = ST_NOSTR;
                    end else if ({1'b0, w_rank} >= r_len) begin
                        n_ovalid = 1'b1;
                        n_ost    = ST_RANGE;
                    end else begin
                        n_ost = ST_OK;
                    end
                end
            end
            S_RDATA: begin
                n_ovalid = 1'b1;
                n_opos   = 10'(w_va);
            end
            S_INIT: begin
                w_wr_en  = 1'b1;
                w_wr_sel = 1'b0;
                w_wr_val = r_k[AW-1:0];
                n_k      = r_k + WW'(1);
                n_cur    = 1'b0;
                n_w      = WW'(1);
                n_lo     = '0;
                if ((r_k + WW'(1)) >= w_n && w_n <= WW'(1)) begin
                    n_complete = 1'b1;
                end
            end
            S_RUN: begin
                n_mid = w_mid;
                n_hi  = w_hi;
                n_a   = r_lo;
                n_b   = w_mid;
                n_k   = r_lo;
            end
            S_STEP: begin
                w_wr_sel = !r_cur;
                if (w_run_a && w_run_b) begin
                    w_req.start = 1'b1;
                end else if (w_run_a) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = w_va;
                    n_a      = r_a + WW'(1);
                    n_k      = r_k + WW'(1);
                end else if (w_run_b) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = w_vb;
                    n_b      = r_b + WW'(1);
                    n_k      = r_k + WW'(1);
                end
            end
            S_WCMP: begin
                w_wr_sel = !r_cur;
                if (w_rsp.done) begin
                    w_wr_en = 1'b1;
                    n_k     = r_k + WW'(1);
                    if (w_rsp.less) begin
                        w_wr_val = w_vb;
                        n_b      = r_b + WW'(1);
                    end else begin
                        w_wr_val = w_va;
                        n_a      = r_a + WW'(1);
                    end
                end
            end
            S_NEXT: begin
                if (w_lo2 < w_n) begin
                    n_lo = w_lo2;
                end else begin
                    n_lo  = '0;
                    n_cur = !r_cur;
                    n_w   = w_w2;
                    if (w_w2 >= w_n) begin
                        n_complete = 1'b1;
                    end
                end
            end
            default: n_ovalid = r_ovalid && !m_tready;
        endcase
    end

    sab_cmp u_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_txt_en),
        .i_wr_addr (w_base[AW-1:0]),
        .i_wr_data (s_tdata[7:0]),
        .i_len     (r_len),
        .i_req     (w_req),
        .o_rsp     (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_complete <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_complete <= n_complete;
            r_ovalid   <= n_ovalid;
        end
        r_cur  <= n_cur;
        r_w    <= n_w;
        r_lo   <= n_lo;
        r_mid  <= n_mid;
        r_hi   <= n_hi;
        r_a    <= n_a;
        r_b    <= n_b;
        r_k    <= n_k;
        r_opos <= n_opos;
        r_ost  <= n_ost;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && !w_wr_sel) begin
            r_ord0[w_wr_addr] <= w_wr_val;
        end
        if (w_wr_en && w_wr_sel) begin
            r_ord1[w_wr_addr] <= w_wr_val;
        end
        r_va0 <= r_ord0[w_rda];
        r_vb0 <= r_ord0[r_b[AW-1:0]];
        r_va1 <= r_ord1[w_rda];
        r_vb1 <= r_ord1[r_b[AW-1:0]];
    end

    `SAB_CHECK(a_merge_count, (r_state == S_LOAD || r_state == S_STEP || r_state == S_WCMP), (r_k + r_mid) == (r_a + r_b))
    `SAB_CHECK(a_err_zero, r_ovalid && r_ost != ST_OK, r_opos == '0)
    `SAB_CHECK(a_cmp_done, w_rsp.done, r_state == S_WCMP)
    `SAB_CHECK_NEXT(a_sort_start, w_acc && s_tuser == CMD_APPEND && s_tlast, r_state == S_INIT)
endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
class sa_scoreboard;
    logic [7:0]  text_mem[1024];
    int          order_mem[1024];
    int          text_len;
    bit          complete;
    logic [11:0] pending_words[$];
    int          mismatches;

    function new();
        text_len = 0;
        complete = 0;
        mismatches = 0;
    endfunction

    function bit suffix_lt(int p, int q);
        while (p < text_len && q < text_len) begin
            if (text_mem[p] != text_mem[q]) return text_mem[p] < text_mem[q];
            p++;
            q++;
        end
        return p >= text_len && q < text_len;
    endfunction

    function void sort_suffixes();
        int scratch[1024];
        int w, lo, mid, hi, a, b, k;
        for (int i = 0; i < text_len; i++) order_mem[i] = i;
        for (w = 1; w < text_len; w *= 2) begin
            for (lo = 0; lo < text_len; lo += 2 * w) begin
                mid = (lo + w < text_len) ? lo + w : text_len;
                hi = (mid + w < text_len) ? mid + w : text_len;
                a = lo;
                b = mid;
                k = lo;
                while (a < mid && b < hi) begin
                    if (suffix_lt(order_mem[b], order_mem[a])) scratch[k++] = order_mem[b++];
                    else scratch[k++] = order_mem[a++];
                end
                while (a < mid) scratch[k++] = order_mem[a++];
                while (b < hi) scratch[k++] = order_mem[b++];
            end
            for (int i = 0; i < text_len; i++) order_mem[i] = scratch[i];
        end
    endfunction

    function void note_word(logic cmd, logic [7:0] bval, logic lst, logic [9:0] rnk);
        logic [9:0] pos;
        sab_pkg::t_status st;
        pos = '0;
        st = sab_pkg::ST_OK;
        if (cmd == sab_pkg::CMD_APPEND) begin
            if (complete) begin
                text_len = 0;
                complete = 0;
            end
            if (text_len >= 1024) begin
                st = sab_pkg::ST_FULL;
            end else begin
                pos = text_len[9:0];
                text_mem[text_len] = bval;
                text_len++;
            end
            if (lst) begin
                sort_suffixes();
                complete = 1;
            end
        end else if (!complete) begin
            st = sab_pkg::ST_NOSTR;
        end else if (rnk >= text_len) begin
            st = sab_pkg::ST_RANGE;
        end else begin
            pos = order_mem[rnk][9:0];
        end
        pending_words.push_back({st, pos});
    endfunction

    function void check_word(logic [15:0] got);
        logic [11:0] exp_w;
        if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
            return;
        end
        exp_w = pending_words.pop_front();
        if (got[11:10] !== exp_w[11:10] || got[9:0] !== exp_w[9:0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: status exp %0d got %0d, position exp %0d got %0d",
                         exp_w[11:10], got[11:10], exp_w[9:0], got[9:0]);
        end
    endfunction
endclass

module tb;
    import sab_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    sa_scoreboard sb;
    int          cycle_count;
    bit          recv_on;
    int          sent_words;

    suffix_array_builder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 3000000) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic pause_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(logic cmd, logic [7:0] bval, logic lst, logic [9:0] rnk);
        int idle_cycles;
        idle_cycles = $urandom_range(0, 16);
        if (idle_cycles != 0) begin
            s_tvalid <= 1'b0;
            pause_cycles(idle_cycles);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= lst;
        s_tdata  <= {6'd0, rnk, bval};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_word(cmd, bval, lst, rnk);
        sent_words++;
    endtask

    task automatic send_string(int len, int alpha);
        for (int i = 0; i < len; i++)
            send_word(CMD_APPEND, 8'($urandom_range(1, alpha)), i == len - 1,
                      10'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_words.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (recv_on && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    initial begin
        int idle_cycles;
        sb = new();
        recv_on = 0;
        m_tready = 0;
        forever begin
            if (!recv_on) begin
                @(posedge i_clk);
                continue;
            end
            idle_cycles = $urandom_range(0, 16);
            if (idle_cycles != 0) begin
                m_tready <= 1'b0;
                pause_cycles(idle_cycles);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
        end
    end

    initial begin
        int len;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        s_tlast = 0;
        i_rst_n = 0;
        sent_words = 0;
        pause_cycles(9);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        recv_on = 1;

        send_word(CMD_READ, 8'h00, 1'b0, 10'd0);
        send_word(CMD_READ, 8'hff, 1'b1, 10'd1023);
        send_word(CMD_APPEND, 8'hff, 1'b0, 10'd1023);
        send_word(CMD_APPEND, 8'h00, 1'b0, 10'd0);
        send_word(CMD_APPEND, 8'h01, 1'b0, 10'd0);
        send_word(CMD_APPEND, 8'hff, 1'b1, 10'd0);
        for (int r = 0; r < 5; r++) send_word(CMD_READ, 8'h00, 1'b0, 10'(r));
        send_word(CMD_READ, 8'h00, 1'b0, 10'd1023);
        send_string(1, 255);
        send_word(CMD_READ, 8'h00, 1'b0, 10'd0);
        send_word(CMD_READ, 8'h00, 1'b0, 10'd1);
        send_string(6, 1);
        for (int r = 0; r < 6; r++) send_word(CMD_READ, 8'h00, 1'b0, 10'(r));
        drain();

        // Fill the store to capacity, with drops and one last word past the end.
        for (int i = 0; i < 1026; i++)
            send_word(CMD_APPEND, 8'($urandom_range(1, 2)), i == 1025, 10'($urandom));
        for (int i = 0; i < 40; i++) send_word(CMD_READ, 8'h00, 1'b0, 10'($urandom));
        send_word(CMD_READ, 8'h00, 1'b0, 10'd1023);
        drain();

        while (sent_words < 1900) begin
            len = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0) begin
                send_word(CMD_APPEND, 8'($urandom), 1'b0, 10'($urandom));
                send_word(CMD_READ, 8'($urandom), 1'($urandom), 10'($urandom));
            end
            send_string(len, $urandom_range(0, 1) ? 3 : 255);
            for (int r = 0; r < len + 2; r++)
                send_word(CMD_READ, 8'($urandom), 1'($urandom),
                          $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, len)));
        end

        drain();
        pause_cycles(20);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
